@@ rtl/hvn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_pkg
// shared types, constants and register codes of the height-map normal block
// ----------------------------------------------------------------------------
package hvn_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int FRAC_BITS_DEF  = 14;
	localparam int MAX_ROWS       = 4096;

	localparam int SAMPLE_W = 8;
	localparam int ROW_W    = 12;   // row index
	localparam int COL_W    = 12;   // column index carried with a vertex job
	localparam int GW_W     = 11;   // grid_width register
	localparam int GH_W     = 13;   // grid_height register
	localparam int GS_W     = 8;    // grid_spacing register
	localparam int DIFF_W   = 11;   // sum of up to four height differences
	localparam int NF_W     = 3;    // face count 0..4
	localparam int MAG_W    = 18;   // magnitude of one summed component
	localparam int USQ_W    = 2 * MAG_W;
	localparam int SQ_W     = USQ_W + 2;

	localparam int QUEUE_DEPTH = 4;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_GRID_SPACING = 2'd2;

	localparam logic [GW_W-1:0] GRID_WIDTH_RST   = 11'd256;
	localparam logic [GH_W-1:0] GRID_HEIGHT_RST  = 13'd256;
	localparam logic [GS_W-1:0] GRID_SPACING_RST = 8'd10;

	typedef struct packed {
		logic [GW_W-1:0] grid_width;
		logic [GH_W-1:0] grid_height;
		logic [GS_W-1:0] grid_spacing;
		logic            restart;
	} cfg_t;

	// one vertex to normalize
	typedef struct packed {
		logic [COL_W-1:0]         col;
		logic [ROW_W-1:0]         row;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dz;
		logic [NF_W-1:0]          nf;
		logic                     last;
	} job_t;

endpackage

`default_nettype wire

@@ rtl/hvn_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_in_if
// height sample channel
// ----------------------------------------------------------------------------
interface hvn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] height_sample;

	modport source (output valid, output height_sample, input ready);
	modport sink (input valid, input height_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/hvn_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_out_if
// vertex normal channel
// ----------------------------------------------------------------------------
interface hvn_out_if;
	logic               valid;
	logic               ready;
	logic [9:0]         vertex_column;
	logic [11:0]        vertex_row;
	logic signed [15:0] normal_x;
	logic [14:0]        normal_y;
	logic signed [15:0] normal_z;
	logic               last_of_run;

	modport source (output valid, output vertex_column, output vertex_row,
		output normal_x, output normal_y, output normal_z, output last_of_run,
		input ready);
	modport sink (input valid, input vertex_column, input vertex_row,
		input normal_x, input normal_y, input normal_z, input last_of_run,
		output ready);
endinterface

`default_nettype wire

@@ rtl/hvn_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_front
// accepts samples, keeps two rows in a line store, builds vertex jobs
// ----------------------------------------------------------------------------
module hvn_front import hvn_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	hvn_in_if.sink samples,
	output job_t  job,
	output logic  job_valid,
	input  logic  job_ready
);

	localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int AW    = CW + 1;
	localparam int DEPTH = 2 ** AW;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_RD0  = 3'd1;
	localparam logic [2:0] F_RD1  = 3'd2;
	localparam logic [2:0] F_RD2  = 3'd3;
	localparam logic [2:0] F_WR   = 3'd4;
	localparam logic [2:0] F_P1   = 3'd5;
	localparam logic [2:0] F_P2   = 3'd6;

	logic [2:0]          state_q;
	logic [CW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	logic [CW-1:0]       item_col_q;
	logic [ROW_W-1:0]    item_row_q;
	logic [SAMPLE_W-1:0] samp_q, old_q, lo2_q, mi0_q, mi1_q, up_left_q, prev_q;
	logic [SAMPLE_W-1:0] rd_a_q, rd_b_q;
	logic [SAMPLE_W-1:0] store_q [DEPTH];
	job_t                job1_q, job2_q;
	logic                has2_q;

	logic [CW:0]     w_eff;
	logic [GH_W-1:0] h_eff;
	logic [AW-1:0]   addr_a, addr_b;
	logic            cur, prv, left, right, down1, is_last, has1;
	logic            accept;
	job_t            job1, job2;

	function automatic logic signed [DIFF_W-1:0] diff(input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b);
		return $signed({3'b000, a}) - $signed({3'b000, b});
	endfunction

	// sums the faces around a vertex: lo row below, mi own row, hi row above
	function automatic job_t make_job(
		input logic [SAMPLE_W-1:0] l0, l1, l2, m0, m1, m2, h0, h1,
		input logic lf, rt, dn, up,
		input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row, input logic last);
		job_t j;
		j.col  = col;
		j.row  = row;
		j.last = last;
		j.dx   = '0;
		j.dz   = '0;
		j.nf   = '0;
		if (lf && dn) begin
			j.dx = j.dx + diff(l0, l1);
			j.dz = j.dz + diff(l0, m0);
			j.nf = j.nf + 3'd1;
		end
		if (rt && dn) begin
			j.dx = j.dx + diff(l1, l2);
			j.dz = j.dz + diff(l1, m1);
			j.nf = j.nf + 3'd1;
		end
		if (lf && up) begin
			j.dx = j.dx + diff(m0, m1);
			j.dz = j.dz + diff(m0, h0);
			j.nf = j.nf + 3'd1;
		end
		if (rt && up) begin
			j.dx = j.dx + diff(m1, m2);
			j.dz = j.dz + diff(m1, h1);
			j.nf = j.nf + 3'd1;
		end
		return j;
	endfunction

	// clamped grid size
	always_comb begin
		if (32'(cfg.grid_width) < 2) w_eff = (CW+1)'(2);
		else if (32'(cfg.grid_width) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(cfg.grid_width);
		if (cfg.grid_height < 13'd2) h_eff = 13'd2;
		else if (32'(cfg.grid_height) > MAX_ROWS) h_eff = GH_W'(MAX_ROWS);
		else h_eff = cfg.grid_height;
	end

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == F_IDLE);

	assign cur     = item_row_q[0];
	assign prv     = ~item_row_q[0];
	assign left    = (item_col_q != '0);
	assign right   = ((AW)'(item_col_q) + (AW)'(1)) < w_eff;
	assign down1   = (item_row_q >= 12'd2);
	assign has1    = (item_row_q != '0);
	assign is_last = ((GH_W)'(item_row_q) + 13'd1) == h_eff;

	always_comb begin
		unique case (state_q)
			F_RD0: begin
				addr_a = {cur, item_col_q};
				addr_b = {cur, item_col_q + CW'(1)};
			end
			F_RD1: begin
				addr_a = {prv, item_col_q - CW'(1)};
				addr_b = {prv, item_col_q};
			end
			F_RD2: begin
				addr_a = {prv, item_col_q + CW'(1)};
				addr_b = {prv, item_col_q};
			end
			default: begin
				addr_a = {cur, item_col_q};
				addr_b = {prv, item_col_q};
			end
		endcase
	end

	// vertex one row down, and on the last row the vertex of this sample
	always_comb begin
		job1 = make_job(up_left_q, old_q, lo2_q, mi0_q, mi1_q, rd_a_q, prev_q, samp_q,
			left, right, down1, 1'b1, COL_W'(item_col_q), item_row_q - 12'd1, !is_last);
		job2 = make_job(mi0_q, mi1_q, rd_a_q, prev_q, samp_q, 8'd0, 8'd0, 8'd0,
			left, right, 1'b1, 1'b0, COL_W'(item_col_q), item_row_q, 1'b1);
	end

	assign job_valid = (state_q == F_P1) || (state_q == F_P2);
	assign job       = (state_q == F_P2) ? job2_q : job1_q;

	// line store: two row slots
	always_ff @(posedge clk) begin
		rd_a_q <= store_q[addr_a];
		rd_b_q <= store_q[addr_b];
		if (state_q == F_WR) begin
			store_q[{cur, item_col_q}] <= samp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q     <= samples.height_sample;
			item_col_q <= col_q;
			item_row_q <= row_q;
		end
		if (state_q == F_RD1) begin
			old_q <= rd_a_q;
			lo2_q <= rd_b_q;
		end
		if (state_q == F_RD2) begin
			mi0_q <= rd_a_q;
			mi1_q <= rd_b_q;
		end
		if (state_q == F_WR) begin
			up_left_q <= old_q;
			prev_q    <= samp_q;
			job1_q    <= job1;
			job2_q    <= job2;
			has2_q    <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cfg.restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (((AW)'(col_q) + (AW)'(1)) >= w_eff) begin
					col_q <= '0;
					if (((GH_W)'(row_q) + 13'd1) >= h_eff) row_q <= '0;
					else row_q <= row_q + 12'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			unique case (state_q)
				F_IDLE: if (accept) state_q <= F_RD0;
				F_RD0:  state_q <= F_RD1;
				F_RD1:  state_q <= F_RD2;
				F_RD2:  state_q <= F_WR;
				F_WR: begin
					if (has1) state_q <= F_P1;
					else if (is_last) state_q <= F_P2;
					else state_q <= F_IDLE;
				end
				F_P1: if (job_ready) state_q <= has2_q ? F_P2 : F_IDLE;
				F_P2: if (job_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/hvn_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module hvn_queue import hvn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_job,
	input  logic push_valid,
	output logic push_ready,
	output job_t pop_job,
	output logic pop_valid,
	input  logic pop_ready
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t          entries_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push, pop;

	assign push_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) count_q <= count_q + (PW+1)'(1);
			else if (pop && !push) count_q <= count_q - (PW+1)'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/hvn_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_norm
// one component: round(u * 2^F / sqrt(sq)) by bit-serial divide then root
// ----------------------------------------------------------------------------
module hvn_norm import hvn_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [USQ_W-1:0]     usq,
	input  logic [SQ_W-1:0]      sq,
	output logic                 done,
	output logic [FRAC_BITS:0]   q
);

	localparam int DW   = 2 * FRAC_BITS + 3;   // quotient u^2*2^(2F+2)/sq
	localparam int RW   = FRAC_BITS + 2;       // root width
	localparam int RMW  = FRAC_BITS + 5;       // root remainder width
	localparam int SDW  = 2 * RW;
	localparam int CNTW = $clog2(DW + 1);

	localparam logic [1:0] N_IDLE = 2'd0;
	localparam logic [1:0] N_DIV  = 2'd1;
	localparam logic [1:0] N_ROOT = 2'd2;

	localparam logic [RW-1:0] ONE = RW'(1) << FRAC_BITS;

	logic [1:0]         phase_q;
	logic [CNTW-1:0]    cnt_q;
	logic               first_q, done_q;
	logic [SQ_W:0]      rem_q;
	logic [SQ_W-1:0]    sq_q;
	logic [DW-1:0]      quo_q;
	logic [SDW-1:0]     sd_q;
	logic [RMW-1:0]     srem_q;
	logic [RW-1:0]      root_q;
	logic [FRAC_BITS:0] q_q;

	logic [SQ_W:0]  div_t, div_rem;
	logic           div_ge, rt_ge;
	logic [DW-1:0]  quo_nx;
	logic [RMW-1:0] rem2, trial;
	logic [RW-1:0]  root_nx, half, capped;
	logic [RW:0]    m1;

	assign div_t   = first_q ? rem_q : {rem_q[SQ_W-1:0], 1'b0};
	assign div_ge  = div_t >= {1'b0, sq_q};
	assign div_rem = div_ge ? div_t - {1'b0, sq_q} : div_t;
	assign quo_nx  = {quo_q[DW-2:0], div_ge};

	assign rem2    = {srem_q[RMW-3:0], sd_q[SDW-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rt_ge   = rem2 >= trial;
	assign root_nx = {root_q[RW-2:0], rt_ge};

	// nearest with ties up: odd 2q-1 stays below the root
	assign m1     = {1'b0, root_nx} + (RW+1)'(1);
	assign half   = m1[RW:1];
	assign capped = (half > ONE) ? ONE : half;

	assign done = done_q;
	assign q    = q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= (SQ_W+1)'(usq);
			sq_q    <= sq;
			quo_q   <= '0;
		end else if (phase_q == N_DIV) begin
			rem_q <= div_rem;
			quo_q <= quo_nx;
			if (cnt_q == CNTW'(DW - 1)) begin
				sd_q   <= SDW'(quo_nx);
				srem_q <= '0;
				root_q <= '0;
			end
		end else if (phase_q == N_ROOT) begin
			srem_q <= rt_ge ? rem2 - trial : rem2;
			root_q <= root_nx;
			sd_q   <= {sd_q[SDW-3:0], 2'b00};
			if (cnt_q == CNTW'(RW - 1)) q_q <= capped[FRAC_BITS:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= N_IDLE;
			cnt_q   <= '0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (start) begin
			phase_q <= N_DIV;
			cnt_q   <= '0;
			first_q <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			unique case (phase_q)
				N_DIV: begin
					first_q <= 1'b0;
					if (cnt_q == CNTW'(DW - 1)) begin
						phase_q <= N_ROOT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				N_ROOT: begin
					if (cnt_q == CNTW'(RW - 1)) begin
						phase_q <= N_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				default: phase_q <= N_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/hvn_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_back
// scales a vertex job, normalizes its three components, holds the result
// ----------------------------------------------------------------------------
module hvn_back import hvn_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t job,
	input  logic job_valid,
	output logic job_ready,
	hvn_out_if.source normals
);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_M1    = 3'd1;
	localparam logic [2:0] B_M2    = 3'd2;
	localparam logic [2:0] B_M3    = 3'd3;
	localparam logic [2:0] B_SUM   = 3'd4;
	localparam logic [2:0] B_START = 3'd5;
	localparam logic [2:0] B_NORM  = 3'd6;
	localparam logic [2:0] B_OUT   = 3'd7;

	logic [2:0]        state_q;
	job_t              job_q;
	logic [MAG_W-1:0]  ax_q, ay_q, az_q;
	logic [15:0]       s2_q;
	logic [USQ_W-1:0]  ax2_q, ay2_q, az2_q;
	logic [SQ_W-1:0]   sq_q;
	logic              out_valid_q;
	logic [9:0]        col_q;
	logic [11:0]       row_q;
	logic signed [15:0] nx_q, nz_q;
	logic [14:0]       ny_q;
	logic              last_q;

	logic [GS_W-1:0]    s;
	logic signed [19:0] px, pz;
	logic [19:0]        abs_x, abs_z;
	logic               start, all_done, load;
	logic [FRAC_BITS:0] qx, qy, qz;
	logic [31:0]        qx32, qy32, qz32;

	assign s         = (cfg.grid_spacing == '0) ? 8'd1 : cfg.grid_spacing;
	assign px        = $signed({1'b0, s}) * job_q.dx;
	assign pz        = $signed({1'b0, s}) * job_q.dz;
	assign abs_x     = px[19] ? 20'(-px) : 20'(px);
	assign abs_z     = pz[19] ? 20'(-pz) : 20'(pz);
	assign start     = (state_q == B_START);
	assign job_ready = (state_q == B_IDLE);
	assign load      = (state_q == B_OUT) && (!out_valid_q || normals.ready);

	assign qx32 = 32'(qx);
	assign qy32 = 32'(qy);
	assign qz32 = 32'(qz);

	logic done_x, done_y, done_z;
	assign all_done = done_x && done_y && done_z;

	hvn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_x (
		.clk(clk), .arst_n(arst_n), .start(start), .usq(ax2_q), .sq(sq_q),
		.done(done_x), .q(qx));
	hvn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_y (
		.clk(clk), .arst_n(arst_n), .start(start), .usq(ay2_q), .sq(sq_q),
		.done(done_y), .q(qy));
	hvn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_z (
		.clk(clk), .arst_n(arst_n), .start(start), .usq(az2_q), .sq(sq_q),
		.done(done_z), .q(qz));

	assign normals.valid         = out_valid_q;
	assign normals.vertex_column = col_q;
	assign normals.vertex_row    = row_q;
	assign normals.normal_x      = nx_q;
	assign normals.normal_y      = ny_q;
	assign normals.normal_z      = nz_q;
	assign normals.last_of_run   = last_q;

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) job_q <= job;
		if (state_q == B_M1) begin
			ax_q <= abs_x[MAG_W-1:0];
			az_q <= abs_z[MAG_W-1:0];
			s2_q <= s * s;
		end
		if (state_q == B_M2) ay_q <= MAG_W'(job_q.nf) * MAG_W'(s2_q);
		if (state_q == B_M3) begin
			ax2_q <= ax_q * ax_q;
			ay2_q <= ay_q * ay_q;
			az2_q <= az_q * az_q;
		end
		if (state_q == B_SUM) sq_q <= SQ_W'(ax2_q) + SQ_W'(ay2_q) + SQ_W'(az2_q);
		if (load) begin
			col_q  <= job_q.col[9:0];
			row_q  <= job_q.row;
			nx_q   <= job_q.dx[DIFF_W-1] ? 16'd0 - qx32[15:0] : qx32[15:0];
			ny_q   <= qy32[14:0];
			nz_q   <= job_q.dz[DIFF_W-1] ? 16'd0 - qz32[15:0] : qz32[15:0];
			last_q <= job_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (normals.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE:  if (job_valid) state_q <= B_M1;
				B_M1:    state_q <= B_M2;
				B_M2:    state_q <= B_M3;
				B_M3:    state_q <= B_SUM;
				B_SUM:   state_q <= B_START;
				B_START: state_q <= B_NORM;
				B_NORM:  if (all_done) state_q <= B_OUT;
				B_OUT:   if (load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/heightmap_vertex_normals.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_vertex_normals
// streaming per-vertex normals of an 8-bit height grid, Q1.FRAC_BITS output
// ----------------------------------------------------------------------------
// samples: one height per item in raster order, row 0 and column 0 first
// normals: one item per vertex with column, row, x/y/z normal and a flag on
//   the final result caused by a sample; vertex (c,r) leaves when sample
//   (c,r+1) arrives, samples of the last row also emit their own vertex
// apb port: grid_width at 0x0, grid_height at 0x4, grid_spacing at 0x8;
//   a write to any of these registers restarts the grid at (0,0); write only while the block is idle
// front: a sample is taken only in idle, then passes the read states F_RD0 to F_RD2
//   of the dual-read line store, the write state and one push state per job
// back: takes a new job only when idle; each result is set by the
//   bit-serial divide and square root of the three component lanes
// a sample yields no result on row 0, one on inner rows, two on the last row
// reset clears the grid position and all valid flags; the line store is not
//   cleared, its entries are always written before they are used
// a stalled receiver holds the result register; the job queue and then the
//   front fill up and samples.ready drops until the receiver takes items
// ----------------------------------------------------------------------------
module heightmap_vertex_normals import hvn_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hvn_in_if.sink      samples,
	hvn_out_if.source   normals,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [GW_W-1:0] grid_width_q;
	logic [GH_W-1:0] grid_height_q;
	logic [GS_W-1:0] grid_spacing_q;
	logic            wr_en, wr_hit;
	logic [1:0]      index;
	cfg_t            cfg;

	// front to queue, queue to back
	job_t fq_job, qb_job;
	logic fq_valid, fq_ready, qb_valid, qb_ready;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign index  = paddr[3:2];

	// only the listed registers restart the grid
	always_comb begin
		unique case (index)
			REG_GRID_WIDTH:   wr_hit = 1'b1;
			REG_GRID_HEIGHT:  wr_hit = 1'b1;
			REG_GRID_SPACING: wr_hit = 1'b1;
			default:          wr_hit = 1'b0;
		endcase
	end

	always_comb begin
		unique case (index)
			REG_GRID_WIDTH:   prdata = 32'(grid_width_q);
			REG_GRID_HEIGHT:  prdata = 32'(grid_height_q);
			REG_GRID_SPACING: prdata = 32'(grid_spacing_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= GRID_WIDTH_RST;
			grid_height_q  <= GRID_HEIGHT_RST;
			grid_spacing_q <= GRID_SPACING_RST;
		end else if (wr_en) begin
			unique case (index)
				REG_GRID_WIDTH:   grid_width_q   <= pwdata[GW_W-1:0];
				REG_GRID_HEIGHT:  grid_height_q  <= pwdata[GH_W-1:0];
				REG_GRID_SPACING: grid_spacing_q <= pwdata[GS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.grid_width   = grid_width_q;
	assign cfg.grid_height  = grid_height_q;
	assign cfg.grid_spacing = grid_spacing_q;
	assign cfg.restart      = wr_en && wr_hit;

	// front: line store and face sums
	hvn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .samples(samples),
		.job(fq_job), .job_valid(fq_valid), .job_ready(fq_ready));

	// decoupling queue
	hvn_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_job(fq_job), .push_valid(fq_valid), .push_ready(fq_ready),
		.pop_job(qb_job), .pop_valid(qb_valid), .pop_ready(qb_ready));

	// back: scaling, normalization and result register
	hvn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.job(qb_job), .job_valid(qb_valid), .job_ready(qb_ready),
		.normals(normals));

endmodule

`default_nettype wire
